// ===== design/rms_automatic_gain_control_defines.svh =====
// assertion macros used by the design file agc_core
`ifndef RMS_AUTOMATIC_GAIN_CONTROL_DEFINES_SVH
`define RMS_AUTOMATIC_GAIN_CONTROL_DEFINES_SVH

// implication checked every clock outside reset
`define AGC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define AGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/agc_pkg.sv =====
`timescale 1ns / 1ps
package agc_pkg;
  localparam int SampleBits = 24;
  localparam int GainFracBits = 20;
  localparam int GainBits = GainFracBits + 4;
  localparam int MsBits = 2 * SampleBits;
  localparam int RmsBits = SampleBits;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] RegTarget = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegMaxGain = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegCoeff = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegMix = 2'd3;

  localparam logic [SampleBits-1:0] TargetReset = 24'd2107134;
  localparam logic [GainBits-1:0] MaxGainReset = 24'd4174469;
  localparam logic [31:0] CoeffReset = 32'd4294877818;
  localparam logic [16:0] MixOne = 17'd65536;
  localparam logic [31:0] CoeffFall = 32'd4290672329;
  localparam logic [GainBits-1:0] GainOne = GainBits'(1) << GainFracBits;
  localparam logic [GainBits-1:0] FloorGain =
    GainBits'(((1 << GainFracBits) + 500) / 1000);
endpackage

// ===== design/agc_if.sv =====
`timescale 1ns / 1ps
interface agc_in_if import agc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SampleBits-1:0] left_sample;
  logic signed [SampleBits-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface agc_out_if import agc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SampleBits-1:0] left_out;
  logic signed [SampleBits-1:0] right_out;
  logic [GainBits-1:0] gain_now;
  modport source (output valid, left_out, right_out, gain_now, input ready);
  modport sink (input valid, left_out, right_out, gain_now, output ready);
endinterface

// ===== design/agc_mac.sv =====
`timescale 1ns / 1ps
// shared 33x32 multiplier, one registered product per cycle
module agc_mac import agc_pkg::*; (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic [64:0] p
);
  always_ff @(posedge clk) begin
    p <= 65'(a) * 65'(b);
  end
endmodule

// ===== design/agc_core.sv =====
`timescale 1ns / 1ps
`include "rms_automatic_gain_control_defines.svh"
module agc_core import agc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [SampleBits-1:0] l_in,
  input  logic signed [SampleBits-1:0] r_in,
  input  logic [SampleBits-1:0]        target_level,
  input  logic [GainBits-1:0]          max_gain,
  input  logic [31:0]                  smooth_coeff,
  input  logic [16:0]                  mix,
  output logic                         busy,
  output logic                         done,
  output logic [SampleBits-1:0]        l_res,
  output logic [SampleBits-1:0]        r_res,
  output logic [GainBits-1:0]          gain_res
);
  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_MS1, S_MS2, S_MS3, S_MS4, S_SQRT, S_DIV, S_CLAMP,
    S_G1, S_G2, S_G3, S_CH
  } state_t;

  state_t state;
  logic [5:0] cnt;
  logic signed [SampleBits-1:0] l_reg, r_reg;
  logic [SampleBits-1:0] mono;
  logic [MsBits-1:0] ms, sq;
  logic [65:0] acc;
  logic [MsBits-1:0] rem_v;
  logic [RmsBits-1:0] root;
  logic [RmsBits+1:0] srem;
  logic [SampleBits+GainFracBits-1:0] quo;
  logic [RmsBits:0] drem;
  logic [GainBits-1:0] gain, desired;
  logic [2:0] ph;
  logic [SampleBits-1:0] mag;
  logic [SampleBits+3:0] wet;
  logic neg;
  logic [32:0] ma;
  logic [31:0] mb;
  logic [64:0] mp;
  logic [SampleBits:0] ssum;
  logic [RmsBits+1:0] strial;
  logic [RmsBits:0] dshift;
  logic [32:0] kc;
  logic [SampleBits-1:0] lim, outv;
  logic [64:0] mixsum;

  agc_mac u_mac (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign kc = 33'h1_0000_0000 - 33'(state == S_G1 || state == S_G2 ?
    (desired < gain ? CoeffFall : smooth_coeff) : smooth_coeff);
  assign ssum = {l_in[SampleBits-1], l_in} + {r_in[SampleBits-1], r_in};
  assign strial = {srem[RmsBits-1:0], rem_v[MsBits-1 -: 2]} - {root, 2'b01};
  assign dshift = {drem[RmsBits-1:0], quo[SampleBits+GainFracBits-1]};

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SQ:  begin ma = 33'(mono); mb = 32'(mono); end
      S_MS1: begin ma = 33'(smooth_coeff); mb = ms[31:0]; end
      S_MS2: begin ma = kc; mb = sq[31:0]; end
      S_MS3: begin ma = 33'(smooth_coeff); mb = 32'(ms[MsBits-1:32]); end
      S_MS4: begin ma = kc; mb = 32'(sq[MsBits-1:32]); end
      S_G1:  begin
        ma = 33'(desired < gain ? CoeffFall : smooth_coeff); mb = 32'(gain);
      end
      S_G2:  begin ma = kc; mb = 32'(desired); end
      S_CH: begin
        case (ph)
          3'd0: begin ma = 33'(mag); mb = 32'(gain); end
          3'd1: begin ma = 33'(mag); mb = 32'(MixOne - mix); end
          3'd2, 3'd3: begin ma = 33'(wet); mb = 32'(mix); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign lim = SampleBits'(1) << (SampleBits - 1);
  assign mixsum = acc[64:0] + mp;
  always_comb begin
    outv = SampleBits'(mixsum[64:16] > 49'(lim) ? 49'(lim) : mixsum[64:16]);
    if (!neg && outv > lim - 1'b1) outv = lim - 1'b1;
    if (neg) outv = -outv;
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      ms <= '0;
      gain <= GainOne;
      cnt <= '0;
      ph <= '0;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          l_reg <= l_in;
          r_reg <= r_in;
          mono <= SampleBits'((ssum[SampleBits] ? -ssum : ssum) >> 1);
          cnt <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd1) begin
            sq <= MsBits'(mp);
            cnt <= '0;
            state <= S_MS1;
          end
        end
        S_MS1: begin cnt <= 6'd1; state <= S_MS2; acc <= '0; end
        S_MS2: begin acc <= 66'(mp); state <= S_MS3; end
        S_MS3: begin acc <= acc + 66'(mp); state <= S_MS4; end
        S_MS4: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd1) acc <= 66'(acc[65:32]) + 66'(mp);
          if (cnt == 6'd2) acc <= acc + 66'(mp);
          if (cnt == 6'd3) begin
            ms <= MsBits'(acc);
            rem_v <= MsBits'(acc);
            root <= '0;
            srem <= '0;
            cnt <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem_v <= rem_v << 2;
          if (!strial[RmsBits+1]) begin
            srem <= strial;
            root <= {root[RmsBits-2:0], 1'b1};
          end else begin
            srem <= {srem[RmsBits-1:0], rem_v[MsBits-1 -: 2]};
            root <= {root[RmsBits-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'(RmsBits - 1)) begin
            cnt <= '0;
            quo <= {target_level, GainFracBits'(0)};
            drem <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (root == '0) begin
            desired <= max_gain;
            state <= S_CLAMP;
          end else begin
            if (dshift >= {1'b0, root}) begin
              drem <= dshift - {1'b0, root};
              quo <= {quo[SampleBits+GainFracBits-2:0], 1'b1};
            end else begin
              drem <= dshift;
              quo <= {quo[SampleBits+GainFracBits-2:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
            if (cnt == 6'(SampleBits + GainFracBits - 1)) state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (root == '0) begin
            desired <= max_gain;
          end else if (quo < 44'(FloorGain)) begin
            desired <= FloorGain > max_gain ? max_gain : FloorGain;
          end else begin
            desired <= quo > 44'(max_gain) ? max_gain : GainBits'(quo);
          end
          state <= S_G1;
        end
        S_G1: begin state <= S_G2; end
        S_G2: begin acc <= 66'(mp); state <= S_G3; end
        S_G3: begin
          gain <= GainBits'((acc[64:0] + mp) >> 32);
          neg <= l_reg[SampleBits-1];
          mag <= SampleBits'(l_reg[SampleBits-1] ? -l_reg : l_reg);
          ph <= '0;
          cnt <= '0;
          state <= S_CH;
        end
        S_CH: begin
          ph <= ph + 1'b1;
          case (ph)
            3'd1: wet <= mp[GainFracBits +: SampleBits+4];
            3'd2: acc <= 66'(mp);
            3'd4: begin
              if (cnt == 6'd0) begin
                l_res <= outv;
                neg <= r_reg[SampleBits-1];
                mag <= SampleBits'(r_reg[SampleBits-1] ? -r_reg : r_reg);
                cnt <= 6'd1;
                ph <= '0;
              end else begin
                r_res <= outv;
                gain_res <= gain;
                done <= 1'b1;
                state <= S_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AGC_ASSERT(a_start_idle, start, state == S_IDLE, "start while busy")
  `AGC_ASSERT_NEXT(a_done_idle, done, state == S_IDLE, "done but not idle")
  `AGC_ASSERT(a_done_quiet, done, !busy, "busy while done")
endmodule

// ===== design/rms_automatic_gain_control.sv =====
`timescale 1ns / 1ps
// channel   dir  beat
// in_ch     in   left_sample, right_sample
// out_ch    out  left_out, right_out, gain_now
// cfg       in   cfg_we, cfg_idx, cfg_data
// 24 square root steps and 44 divide steps dominate the core busy time,
// the rest is the square, smoothing, gain update and both channel scales
// zero mean square skips the divide steps
// ready only while the core is idle and no result waits
// rst synchronous active high, gain 1.0 and mean square 0 after reset
module rms_automatic_gain_control import agc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  agc_in_if.sink                 in_ch,
  agc_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data
);
  logic [SampleBits-1:0] target_level;
  logic [GainBits-1:0] max_gain;
  logic [31:0] smooth_coeff;
  logic [16:0] wet_mix, mix;
  logic busy, done, start;
  logic [SampleBits-1:0] l_res, r_res;
  logic [GainBits-1:0] g_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TargetReset;
      max_gain <= MaxGainReset;
      smooth_coeff <= CoeffReset;
      wet_mix <= MixOne;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegTarget: target_level <= cfg_data[SampleBits-1:0];
        RegMaxGain: max_gain <= cfg_data[GainBits-1:0];
        RegCoeff: smooth_coeff <= cfg_data;
        RegMix: wet_mix <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign mix = wet_mix > MixOne ? MixOne : wet_mix;
  assign in_ch.ready = !busy && !done && !out_ch.valid;
  assign start = in_ch.valid && in_ch.ready;

  agc_core u_core (
    .clk, .rst, .start,
    .l_in(in_ch.left_sample), .r_in(in_ch.right_sample),
    .target_level, .max_gain, .smooth_coeff, .mix,
    .busy, .done, .l_res, .r_res, .gain_res(g_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (done) begin
      out_ch.valid <= 1'b1;
      out_ch.left_out <= l_res;
      out_ch.right_out <= r_res;
      out_ch.gain_now <= g_res;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end
endmodule

// ===== sim/agc_tb_if.sv =====
`timescale 1ns / 1ps
// the block's channel interfaces come with the design; this file only holds
// the beat record the checker queues, so the top file stays self-contained
package agc_tb_pkg;
  import agc_pkg::*;
  typedef struct packed {
    logic signed [SampleBits-1:0] left_out;
    logic signed [SampleBits-1:0] right_out;
    logic [GainBits-1:0] gain_now;
  } agc_beat_t;
endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import agc_pkg::*;
  import agc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = RegTarget;
  logic [CfgDataBits-1:0] cfg_data = '0;

  agc_in_if in_ch ();
  agc_out_if out_ch ();

  rms_automatic_gain_control u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [SampleBits-1:0] target_q;
  logic [GainBits-1:0] max_gain_q;
  logic [31:0] coeff_q;
  logic [16:0] mix_q;
  logic [63:0] ms_q;
  logic [GainBits-1:0] gain_q;

  agc_beat_t pending_out[$];
  int errors = 0;
  bit hold_rx = 1'b0;
  int long_stall = 0;
  int rx_mode = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [63:0] blend64(logic [31:0] c, logic [63:0] a, logic [63:0] b);
    logic [127:0] s;
    s = 128'(c) * 128'(a) + (128'(1) << 32) * 128'(b) - 128'(c) * 128'(b);
    return 64'(s >> 32);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if (128'(r | (64'd1 << b)) * 128'(r | (64'd1 << b)) <= 128'(v)) r = r | (64'd1 << b);
    return r;
  endfunction

  function automatic logic [SampleBits-1:0] scale_ch(logic signed [SampleBits-1:0] x,
                                                       logic [GainBits-1:0] g, logic [16:0] m);
    logic [63:0] mag, wet, y, lim;
    mag = x < 0 ? 64'(-64'(x)) : 64'(x);
    wet = (mag * g) >> GainFracBits;
    y = (mag * (64'(MixOne) - m) + wet * m) >> 16;
    lim = 64'd1 << (SampleBits - 1);
    if (x < 0) begin
      if (y > lim) y = lim;
      return SampleBits'(-y);
    end
    if (y > lim - 1) y = lim - 1;
    return SampleBits'(y);
  endfunction

  function automatic agc_beat_t predict_gain(logic signed [SampleBits-1:0] l,
                                             logic signed [SampleBits-1:0] r);
    agc_beat_t o;
    logic signed [63:0] sum;
    logic [63:0] mono, rms, want;
    logic [16:0] m;
    sum = 64'(l) + 64'(r);
    mono = (sum < 0 ? 64'(-sum) : 64'(sum)) >> 1;
    ms_q = blend64(coeff_q, ms_q, mono * mono);
    rms = root64(ms_q);
    want = rms == 0 ? 64'(max_gain_q) : (64'(target_q) << GainFracBits) / rms;
    if (want < 64'(FloorGain)) want = 64'(FloorGain);
    if (want > 64'(max_gain_q)) want = 64'(max_gain_q);
    gain_q = GainBits'(blend64(want < 64'(gain_q) ? CoeffFall : coeff_q,
                               64'(gain_q), want));
    m = mix_q > MixOne ? MixOne : mix_q;
    o.left_out = scale_ch(l, gain_q, m);
    o.right_out = scale_ch(r, gain_q, m);
    o.gain_now = gain_q;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  int gap_rx;
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_out.size() == 0) report("unexpected beat", 0, 0);
      else begin
        agc_beat_t e;
        e = pending_out.pop_front();
        if (out_ch.left_out !== e.left_out) report("left_out", out_ch.left_out, e.left_out);
        if (out_ch.right_out !== e.right_out) report("right_out", out_ch.right_out, e.right_out);
        if (out_ch.gain_now !== e.gain_now) report("gain_now", out_ch.gain_now, e.gain_now);
      end
    end
    if (long_stall > 0) begin
      long_stall <= long_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_rx) begin
      long_stall <= 400;
      out_ch.ready <= 1'b0;
    end else if (rx_mode == 0) out_ch.ready <= 1'b1;
    else if (gap_rx > 0) begin
      gap_rx <= gap_rx - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        gap_rx <= $urandom_range(0, 9) == 0 ? $urandom_range(50, 300) : $urandom_range(1, 4);
    end
  end

  initial gap_rx = 0;

  task automatic send_pair(logic [SampleBits-1:0] l, logic [SampleBits-1:0] r, bit gaps);
    int g;
    g = 0;
    if (gaps && $urandom_range(0, 3) == 0)
      g = $urandom_range(0, 9) == 0 ? $urandom_range(50, 300) : $urandom_range(1, 5);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_sample <= l;
    in_ch.right_sample <= r;
    do @(posedge clk); while (!in_ch.ready);
    pending_out.push_back(predict_gain(l, r));
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegTarget: target_q = v[SampleBits-1:0];
      RegMaxGain: max_gain_q = v[GainBits-1:0];
      RegCoeff: coeff_q = v;
      RegMix: mix_q = v[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [SampleBits-1:0] rand_sample(int level);
    logic [SampleBits-1:0] s;
    s = SampleBits'($urandom);
    case (level)
      0: return SampleBits'($signed(s) >>> $urandom_range(8, 22));
      1: return SampleBits'($signed(s) >>> $urandom_range(0, 6));
      default: return s;
    endcase
  endfunction

  task automatic test_directed;
    logic [SampleBits-1:0] mx, mn;
    mx = {1'b0, {(SampleBits-1){1'b1}}};
    mn = {1'b1, {(SampleBits-1){1'b0}}};
    send_pair('0, '0, 0);
    send_pair('0, '0, 0);
    send_pair(mx, mx, 0);
    send_pair(mn, mn, 0);
    send_pair(mx, mn, 0);
    send_pair(mn, '1, 0);
    send_pair(SampleBits'(1), SampleBits'(-1), 0);
    send_pair(SampleBits'(1), '0, 0);
    send_pair('1, '1, 0);
    repeat (4) send_pair(SampleBits'(24'h001000), SampleBits'(24'hFFF000), 0);
    repeat (4) send_pair(mx, mx, 0);
    drain();
  endtask

  task automatic test_random_run(int n, bit gaps);
    int lvl;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) lvl = $urandom_range(0, 2);
      send_pair(rand_sample(lvl), rand_sample(lvl), gaps);
    end
  endtask

  task automatic test_config_sweep;
    write_reg(RegTarget, 32'd529292);
    write_reg(RegMaxGain, 32'd1048576);
    write_reg(RegCoeff, 32'd0);
    write_reg(RegMix, 32'd0);
    test_random_run(150, 1);
    drain();
    write_reg(RegTarget, 32'd8388608);
    write_reg(RegMaxGain, 32'd16619000);
    write_reg(RegCoeff, 32'hFFFFFFFF);
    write_reg(RegMix, 32'd131071);
    test_random_run(150, 1);
    drain();
    // ceiling below floor lets max_gain win
    write_reg(RegMaxGain, 32'd5);
    write_reg(RegCoeff, 32'h4000_0000);
    write_reg(RegMix, 32'd32768);
    test_random_run(100, 1);
    drain();
    write_reg(RegMaxGain, 32'hFFFFFFFF);
    write_reg(RegTarget, 32'hFFFFFFFF);
    write_reg(RegCoeff, 32'hF000_0000);
    write_reg(RegMix, 32'd70000);
    test_random_run(100, 1);
    drain();
    for (int k = 0; k < 8; k++) begin
      write_reg(RegTarget, $urandom_range(529292, 8388608));
      write_reg(RegMaxGain, $urandom_range(1048576, 16619000));
      write_reg(RegCoeff, $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF_0000 | $urandom_range(0, 65535));
      write_reg(RegMix, $urandom_range(0, 65536));
      test_random_run(100, 1);
      drain();
    end
  endtask

  task automatic test_backpressure;
    hold_rx = 1'b1;
    wait (long_stall > 0);
    hold_rx = 1'b0;
    test_random_run(20, 0);
    drain();
  endtask

  initial begin
    target_q = TargetReset;
    max_gain_q = MaxGainReset;
    coeff_q = CoeffReset;
    mix_q = MixOne;
    ms_q = '0;
    gain_q = GainOne;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    rx_mode = 1;
    test_random_run(300, 1);
    drain();
    rx_mode = 0;
    test_random_run(100, 0);
    drain();
    rx_mode = 1;
    test_backpressure();
    test_config_sweep();
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
